FILE: rtl/atelm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// atelm_pkg: shared types and constants of the event line matcher
// Word layouts of both channels, operation and result codes, character
// constants and the hex digit decoder.
// ---------------------------------------------------------------------------
package atelm_pkg;

  localparam logic [1:0] OP_RECV    = 2'd0;
  localparam logic [1:0] OP_PATTERN = 2'd1;
  localparam logic [1:0] OP_DESC    = 2'd2;

  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [2:0] PAY_NONE   = 3'd7;
  localparam logic [2:0] ARG_MAX    = 3'd7;
  localparam logic [6:0] CMD_LEN    = 7'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_in;
    logic [2:0] event_slot;
    logic [5:0] pattern_pos;
    logic [6:0] pattern_len;
    logic [2:0] payload_arg;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] fired_slot;
    logic [7:0] data_byte;
  } out_word_t;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      n = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      n = 4'(c - 8'h57);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/atelm_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// atelm_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module atelm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/at_event_line_matcher_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// at_event_line_matcher_unit: response line matcher against an event table
// Input words load the event table (patterns, descriptors) or feed one received character.
// Output words report a fired event at line end or one payload byte.
// ---------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i / in_stall_o / in_data_i): one word per item;
//     the block stalls the channel while an item is in work.
//   out channel (out_valid_o / out_stall_i / out_data_o): at most one word
//     per item, held in an output register until taken.
//   cfg channel (cfg_valid_i / cfg_ready_o / cfg_data_i): event_count,
//     taken while no item is in work.
//   Every item passes through S_EXEC; a checked argument character also
//   passes through S_ARG_CMP (one pattern RAM read). A command character
//   reads and compares one prefix character at a time (S_CMD_RD, S_CMD_CMP)
//   on the single pattern RAM port, slot by slot up to MAX_EVENTS slots.
//   Reset clears the search and event_count; the tables are undefined until
//   loaded. While the receiver stalls a pending word, the block keeps
//   accepting items and waits only when a new word must be issued.
// ---------------------------------------------------------------------------
module at_event_line_matcher_unit
  import atelm_pkg::*;
#(
  parameter int MAX_EVENTS    = 8,
  parameter int PATTERN_DEPTH = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [3:0] cfg_data_i
);

  localparam int SLOT_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int SCAN_W = $clog2(MAX_EVENTS + 1);
  localparam int RAM_D  = MAX_EVENTS * PATTERN_DEPTH;
  localparam int AW     = (RAM_D > 1) ? $clog2(RAM_D) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CMD_RD,
    S_CMD_CMP,
    S_ARG_CMP
  } state_e;

  function automatic logic [AW-1:0] ram_addr(input logic [SLOT_W-1:0] s,
                                             input logic [7:0] p);
    return AW'(32'(s) * PATTERN_DEPTH + 32'(p));
  endfunction

  state_e            state_q, state_d;
  in_word_t          in_q;
  logic [3:0]        evcnt_q, evcnt_d;
  logic [6:0]        mpos_q, mpos_d;
  logic [7:0]        cmd_q [3];
  logic [7:0]        cmd_d [3];
  logic              mvalid_q, mvalid_d;
  logic [SLOT_W-1:0] mslot_q, mslot_d;
  logic [2:0]        argc_q, argc_d;
  logic              pend_q, pend_d;
  logic [3:0]        hinib_q, hinib_d;
  logic [SCAN_W-1:0] scan_slot_q, scan_slot_d;
  logic [1:0]        scan_k_q, scan_k_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q, out_d;

  logic [6:0]        len_q [MAX_EVENTS];
  logic [2:0]        pay_q [MAX_EVENTS];

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [7:0]        ram_rdata;

  logic [SCAN_W-1:0] lim;
  logic              out_free;
  logic              is_eol;
  logic              is_comma;
  logic              pay_hit;
  logic              in_pattern;
  logic [3:0]        nib;
  logic [2:0]        cur_pay;
  logic [6:0]        cur_len;
  logic [2:0]        argc_inc;

  atelm_ram #(
    .WIDTH (8),
    .DEPTH (RAM_D)
  ) u_pattern_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_q.char_in),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (32'(evcnt_q) > MAX_EVENTS) begin
      lim = SCAN_W'(MAX_EVENTS);
    end else begin
      lim = SCAN_W'(evcnt_q);
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_eol     = (in_q.char_in == CH_CR) || (in_q.char_in == CH_LF);
  assign is_comma   = (in_q.char_in == CH_COMMA);
  assign cur_pay    = pay_q[mslot_q];
  assign cur_len    = len_q[mslot_q];
  assign pay_hit    = (cur_pay != PAY_NONE) && (cur_pay == argc_q);
  assign in_pattern = (32'(mpos_q) < 32'(cur_len)) && (32'(mpos_q) < PATTERN_DEPTH);
  assign nib        = hex_nibble(in_q.char_in);
  assign argc_inc   = (is_comma && argc_q < ARG_MAX) ? argc_q + 3'd1 : argc_q;

  assign ram_we    = (state_q == S_EXEC) && (in_q.operation == OP_PATTERN) &&
                     (32'(in_q.event_slot) < MAX_EVENTS) &&
                     (32'(in_q.pattern_pos) < PATTERN_DEPTH);
  assign ram_waddr = ram_addr(SLOT_W'(in_q.event_slot), 8'(in_q.pattern_pos));

  always_comb begin
    if (state_q == S_CMD_RD) begin
      ram_raddr = ram_addr(SLOT_W'(scan_slot_q), 8'(scan_k_q));
    end else begin
      ram_raddr = ram_addr(mslot_q, 8'(mpos_q));
    end
  end

  always_comb begin
    state_d     = state_q;
    evcnt_d     = evcnt_q;
    mpos_d      = mpos_q;
    cmd_d       = cmd_q;
    mvalid_d    = mvalid_q;
    mslot_d     = mslot_q;
    argc_d      = argc_q;
    pend_d      = pend_q;
    hinib_d     = hinib_q;
    scan_slot_d = scan_slot_q;
    scan_k_d    = scan_k_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (cfg_valid_i && cfg_ready_o) begin
      evcnt_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        if (in_q.operation == OP_RECV) begin
          if (is_eol) begin
            if (mvalid_q && !out_free) begin
              state_d = S_EXEC;
            end else begin
              if (mvalid_q) begin
                out_valid_d = 1'b1;
                out_d = '{kind: KIND_EVENT, fired_slot: 3'(mslot_q), data_byte: 8'd0};
              end
              mpos_d = '0; cmd_d = '{default: 8'd0}; mvalid_d = 1'b0;
              mslot_d = '0; argc_d = '0; pend_d = 1'b0; hinib_d = '0;
            end
          end else if (mpos_q < CMD_LEN) begin
            cmd_d[mpos_q[1:0]] = in_q.char_in;
            mpos_d      = mpos_q + 7'd1;
            scan_slot_d = '0;
            scan_k_d    = '0;
            state_d     = S_CMD_RD;
          end else if (pay_hit) begin
            if (pend_q && !out_free) begin
              state_d = S_EXEC;
            end else begin
              if (pend_q) begin
                out_valid_d = 1'b1;
                out_d = '{kind: KIND_BYTE, fired_slot: 3'(mslot_q),
                          data_byte: {hinib_q, nib}};
                pend_d  = 1'b0;
                hinib_d = '0;
              end else begin
                pend_d  = 1'b1;
                hinib_d = nib;
              end
              argc_d = argc_inc;
            end
          end else if (in_pattern) begin
            state_d = S_ARG_CMP;
          end else begin
            argc_d = argc_inc;
          end
        end
      end
      S_CMD_RD: begin
        if (scan_slot_q >= lim) begin
          mpos_d = '0; cmd_d = '{default: 8'd0}; mvalid_d = 1'b0;
          mslot_d = '0; argc_d = '0; pend_d = 1'b0; hinib_d = '0;
          state_d = S_IDLE;
        end else begin
          state_d = S_CMD_CMP;
        end
      end
      S_CMD_CMP: begin
        if (ram_rdata == cmd_q[scan_k_q]) begin
          if (7'(scan_k_q) + 7'd1 == mpos_q) begin
            if (mpos_q == CMD_LEN) begin
              mvalid_d = 1'b1;
              mslot_d  = SLOT_W'(scan_slot_q);
            end
            state_d = S_IDLE;
          end else begin
            scan_k_d = scan_k_q + 2'd1;
            state_d  = S_CMD_RD;
          end
        end else begin
          scan_slot_d = scan_slot_q + SCAN_W'(1);
          scan_k_d    = '0;
          state_d     = S_CMD_RD;
        end
      end
      S_ARG_CMP: begin
        state_d = S_IDLE;
        if (ram_rdata == CH_QMARK || ram_rdata == in_q.char_in) begin
          mpos_d = mpos_q + 7'd1;
          argc_d = argc_inc;
        end else begin
          mpos_d = '0; cmd_d = '{default: 8'd0}; mvalid_d = 1'b0;
          mslot_d = '0; argc_d = '0; pend_d = 1'b0; hinib_d = '0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      evcnt_q     <= '0;
      mpos_q      <= '0;
      cmd_q       <= '{default: 8'd0};
      mvalid_q    <= 1'b0;
      mslot_q     <= '0;
      argc_q      <= '0;
      pend_q      <= 1'b0;
      hinib_q     <= '0;
      scan_slot_q <= '0;
      scan_k_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      evcnt_q     <= evcnt_d;
      mpos_q      <= mpos_d;
      cmd_q       <= cmd_d;
      mvalid_q    <= mvalid_d;
      mslot_q     <= mslot_d;
      argc_q      <= argc_d;
      pend_q      <= pend_d;
      hinib_q     <= hinib_d;
      scan_slot_q <= scan_slot_d;
      scan_k_q    <= scan_k_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (state_q == S_EXEC && in_q.operation == OP_DESC &&
        32'(in_q.event_slot) < MAX_EVENTS) begin
      len_q[SLOT_W'(in_q.event_slot)] <= in_q.pattern_len;
      pay_q[SLOT_W'(in_q.event_slot)] <= in_q.payload_arg;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: tb/atelm_line_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// atelm_line_checker: in-order scoreboard for the event line matcher
// Tracks the event table, event_count and the line search state from the
// words accepted on the input and configuration channels. Works out the
// output word each character causes and compares every accepted output word,
// field by field, with the oldest one due.
// ---------------------------------------------------------------------------
module atelm_line_checker
  import atelm_pkg::*;
#(
  parameter int MAX_EVENTS    = 8,
  parameter int PATTERN_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_word_t   in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_word_t  out_data_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [3:0] cfg_data_i,
  output int         outstanding_o,
  output int         errors_o
);

  logic [7:0]  pat_mem [MAX_EVENTS][PATTERN_DEPTH];
  logic [6:0]  len_mem [MAX_EVENTS];
  logic [2:0]  pay_mem [MAX_EVENTS];
  logic [3:0]  event_count;
  logic [6:0]  match_pos;
  logic [23:0] cmd_seen;
  logic        matched;
  logic [2:0]  matched_slot;
  logic [2:0]  arg_cnt;
  logic        nib_pending;
  logic [3:0]  hi_nib;
  out_word_t   line_results_q[$];
  int          mismatches;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c[3:0];
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  task automatic clear_search();
    match_pos    = '0;
    cmd_seen     = '0;
    matched      = 1'b0;
    matched_slot = '0;
    arg_cnt      = '0;
    nib_pending  = 1'b0;
    hi_nib       = '0;
  endtask

  task automatic match_char(input logic [7:0] c);
    out_word_t  w;
    int         lim;
    logic       hit;
    logic       agree;
    logic [2:0] sl;
    logic [6:0] plen;
    logic [7:0] p;
    if (c == CH_CR || c == CH_LF) begin
      if (matched) begin
        w.kind       = KIND_EVENT;
        w.fired_slot = matched_slot;
        w.data_byte  = '0;
        line_results_q.push_back(w);
      end
      clear_search();
      return;
    end
    if (match_pos < CMD_LEN) begin
      cmd_seen  = cmd_seen | (24'(c) << (8 * match_pos));
      match_pos = match_pos + 7'd1;
      lim = (event_count > MAX_EVENTS) ? MAX_EVENTS : int'(event_count);
      hit = 1'b0;
      for (int s = 0; s < lim; s++) begin
        if (!hit) begin
          agree = 1'b1;
          for (int k = 0; k < match_pos; k++) begin
            if (pat_mem[s][k] != cmd_seen[8*k +: 8]) agree = 1'b0;
          end
          if (agree) begin
            hit = 1'b1;
            if (match_pos == CMD_LEN) begin
              matched      = 1'b1;
              matched_slot = 3'(s);
            end
          end
        end
      end
      if (!hit) clear_search();
      return;
    end
    sl   = matched_slot;
    plen = (len_mem[sl] > PATTERN_DEPTH) ? 7'(PATTERN_DEPTH) : len_mem[sl];
    if (pay_mem[sl] != PAY_NONE && pay_mem[sl] == arg_cnt) begin
      if (nib_pending) begin
        w.kind       = KIND_BYTE;
        w.fired_slot = sl;
        w.data_byte  = {hi_nib, nibble_of(c)};
        line_results_q.push_back(w);
        nib_pending = 1'b0;
        hi_nib      = '0;
      end else begin
        hi_nib      = nibble_of(c);
        nib_pending = 1'b1;
      end
    end else if (match_pos < plen) begin
      p = pat_mem[sl][match_pos];
      if (p == CH_QMARK || p == c) begin
        match_pos = match_pos + 7'd1;
      end else begin
        clear_search();
        return;
      end
    end
    if (c == CH_COMMA && arg_cnt < ARG_MAX) arg_cnt = arg_cnt + 3'd1;
  endtask

  task automatic apply_word(input in_word_t w);
    case (w.operation)
      OP_RECV: begin
        match_char(w.char_in);
      end
      OP_PATTERN: begin
        if (w.event_slot < MAX_EVENTS && w.pattern_pos < PATTERN_DEPTH) begin
          pat_mem[w.event_slot][w.pattern_pos] = w.char_in;
        end
      end
      OP_DESC: begin
        if (w.event_slot < MAX_EVENTS) begin
          len_mem[w.event_slot] = w.pattern_len;
          pay_mem[w.event_slot] = w.payload_arg;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (line_results_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: output word with none due: kind=%0d slot=%0d byte=%02h",
                 $time, got.kind, got.fired_slot, got.data_byte);
      end
      return;
    end
    want = line_results_q.pop_front();
    if (got.kind !== want.kind || got.fired_slot !== want.fired_slot ||
        got.data_byte !== want.data_byte) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: mismatch kind/slot/byte: expected %0d/%0d/%02h, got %0d/%0d/%02h",
                 $time, want.kind, want.fired_slot, want.data_byte,
                 got.kind, got.fired_slot, got.data_byte);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < MAX_EVENTS; s++) begin
        for (int k = 0; k < PATTERN_DEPTH; k++) pat_mem[s][k] = '0;
        len_mem[s] = '0;
        pay_mem[s] = '0;
      end
      event_count = '0;
      clear_search();
      line_results_q.delete();
      mismatches = 0;
      outstanding_o <= 0;
      errors_o      <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_word(out_data_i);
      if (cfg_valid_i && cfg_ready_i) event_count = cfg_data_i;
      if (in_valid_i && !in_stall_i) apply_word(in_data_i);
      outstanding_o <= line_results_q.size();
      errors_o      <= mismatches;
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the event line matcher
// Loads the whole event table, runs a few directed lines, then phases of
// random response lines, broken lines, noise and table rewrites under
// several event_count settings and idling patterns. A checker module beside
// the block predicts and compares every output word.
// ---------------------------------------------------------------------------
module testbench;
  import atelm_pkg::*;

  localparam int MAX_EVENTS    = 8;
  localparam int PATTERN_DEPTH = 64;
  localparam int ITEM_TARGET   = 1850;
  localparam int PHASES        = 8;
  localparam int SETTLE_CYCLES = 60;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_word_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data  = '0;
  int         outstanding;
  int         errors;

  int         snd_idle_pct  = 0;
  int         rcv_stall_pct = 0;
  int         sent          = 0;
  logic [3:0] cur_count     = '0;
  logic [7:0] tbl_pat [MAX_EVENTS][PATTERN_DEPTH];
  logic [6:0] tbl_len [MAX_EVENTS];
  logic [2:0] tbl_pay [MAX_EVENTS];

  logic [3:0] phase_count [PHASES] = '{4'd8, 4'd15, 4'd3, 4'd0, 4'd8, 4'd1, 4'd5, 4'd12};

  at_event_line_matcher_unit #(
    .MAX_EVENTS    (MAX_EVENTS),
    .PATTERN_DEPTH (PATTERN_DEPTH)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  atelm_line_checker #(
    .MAX_EVENTS    (MAX_EVENTS),
    .PATTERN_DEPTH (PATTERN_DEPTH)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .outstanding_o (outstanding),
    .errors_o      (errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_stall_pct);
  end

  function automatic in_word_t mk_word(input logic [1:0] op, input logic [7:0] c);
    in_word_t    w;
    logic [31:0] r;
    r = $urandom;
    w = r[$bits(in_word_t)-1:0];
    w.operation = op;
    w.char_in   = c;
    return w;
  endfunction

  function automatic logic [7:0] cmd_char();
    logic [7:0] c;
    case ($urandom_range(3))
      0:       c = "+";
      1:       c = "R";
      2:       c = "S";
      default: c = "X";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] free_char();
    logic [7:0] c;
    if ($urandom_range(4) != 0) return 8'($urandom_range(32, 126));
    do c = 8'($urandom_range(255)); while (c == CH_CR || c == CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    string digits = "0123456789ABCDEFabcdef";
    if ($urandom_range(9) == 0) return free_char();
    return digits[$urandom_range(digits.len() - 1)];
  endfunction

  function automatic logic [7:0] arg_char();
    string alnum = "0123456789ABCDEFabcdefOKRX";
    int    r;
    r = $urandom_range(99);
    if (r < 20) return CH_COMMA;
    if (r < 50) return CH_QMARK;
    if (r < 95) return alnum[$urandom_range(alnum.len() - 1)];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [6:0] rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 7'($urandom_range(3));
    if (r < 20) return 7'($urandom_range(65, 127));
    if (r < 30) return 7'(PATTERN_DEPTH);
    return 7'($urandom_range(4, 24));
  endfunction

  function automatic int pick_slot();
    int lim;
    lim = (cur_count > MAX_EVENTS) ? MAX_EVENTS : int'(cur_count);
    if (lim == 0) return $urandom_range(MAX_EVENTS - 1);
    return $urandom_range(lim - 1);
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
      1:       begin snd_idle_pct = 52; rcv_stall_pct = 0;  end
      2:       begin snd_idle_pct = 0;  rcv_stall_pct = 52; end
      default: begin snd_idle_pct = 22; rcv_stall_pct = 22; end
    endcase
  endtask

  task automatic put_word(input in_word_t w);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (w.operation != OP_UNUSED) sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(input logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_count = v;
  endtask

  task automatic send_char(input logic [7:0] c);
    put_word(mk_word(OP_RECV, c));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic write_pat(input int s, input int pos, input logic [7:0] c);
    in_word_t w;
    w = mk_word(OP_PATTERN, c);
    w.event_slot  = 3'(s);
    w.pattern_pos = 6'(pos);
    tbl_pat[s][pos] = c;
    put_word(w);
  endtask

  task automatic write_desc(input int s, input logic [6:0] len, input logic [2:0] pay);
    in_word_t w;
    w = mk_word(OP_DESC, 8'($urandom_range(255)));
    w.event_slot  = 3'(s);
    w.pattern_len = len;
    w.payload_arg = pay;
    tbl_len[s] = len;
    tbl_pay[s] = pay;
    put_word(w);
  endtask

  task automatic write_slot(input int s, input string head, input logic [6:0] len,
                            input logic [2:0] pay);
    logic [7:0] c;
    for (int pos = 0; pos < PATTERN_DEPTH; pos++) begin
      if (pos < head.len()) c = head[pos];
      else if (pos < 3) c = cmd_char();
      else c = arg_char();
      write_pat(s, pos, c);
    end
    write_desc(s, len, pay);
  endtask

  task automatic rewrite_entry();
    int s;
    int pos;
    s   = $urandom_range(MAX_EVENTS - 1);
    pos = $urandom_range(PATTERN_DEPTH - 1);
    if ($urandom_range(3) == 0) write_desc(s, rand_len(), 3'($urandom_range(7)));
    else write_pat(s, pos, (pos < 3) ? cmd_char() : arg_char());
  endtask

  task automatic send_line(input int s, input bit broken);
    logic [7:0] line_q[$];
    logic [7:0] c;
    int         plen;
    int         pos;
    int         arg;
    for (int k = 0; k < 3; k++) line_q.push_back(tbl_pat[s][k]);
    plen = (tbl_len[s] > PATTERN_DEPTH) ? PATTERN_DEPTH : int'(tbl_len[s]);
    pos  = 3;
    arg  = 0;
    while (pos < plen) begin
      if (tbl_pay[s] != PAY_NONE && tbl_pay[s] == arg) begin
        repeat ($urandom_range(6)) line_q.push_back(hex_char());
        line_q.push_back(CH_COMMA);
        arg++;
      end else begin
        c = tbl_pat[s][pos];
        if (c == CH_QMARK) c = free_char();
        line_q.push_back(c);
        pos++;
        if (c == CH_COMMA && arg < ARG_MAX) arg++;
      end
    end
    if (tbl_pay[s] != PAY_NONE && arg <= tbl_pay[s]) begin
      while (arg < tbl_pay[s]) begin
        line_q.push_back(CH_COMMA);
        arg++;
      end
      repeat ($urandom_range(8)) line_q.push_back(hex_char());
    end
    repeat ($urandom_range(2)) line_q.push_back(free_char());
    if (broken) line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
    foreach (line_q[i]) begin
      if ($urandom_range(39) == 0) rewrite_entry();
      send_char(line_q[i]);
    end
    send_char($urandom_range(1) ? CH_CR : CH_LF);
    if ($urandom_range(7) == 0) send_char(CH_LF);
  endtask

  task automatic run_traffic(input int budget);
    int stop;
    int r;
    stop = sent + budget;
    while (sent < stop) begin
      r = $urandom_range(99);
      if (r < 72) begin
        send_line(pick_slot(), $urandom_range(9) == 0);
      end else if (r < 84) begin
        repeat ($urandom_range(1, 6)) begin
          send_char($urandom_range(1) ? cmd_char() : 8'($urandom_range(255)));
        end
      end else if (r < 94) begin
        rewrite_entry();
      end else if (r < 98) begin
        put_word(mk_word(OP_UNUSED, 8'($urandom_range(255))));
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0);
    set_count(4'd8);
    for (int s = 0; s < MAX_EVENTS; s++) begin
      if (s == 0) write_slot(s, "+RX,?,OK", 7'd8, 3'd1);
      else if (s == 1) write_slot(s, "+RS,??", 7'd6, PAY_NONE);
      else write_slot(s, "", rand_len(), 3'($urandom_range(7)));
    end

    set_idling(3);
    send_text("+RX,fAz9B");
    send_char(CH_CR);
    send_text("+RS,12");
    send_char(CH_LF);
    send_text("+RQ+RS!");
    send_char(CH_LF);
    put_word(mk_word(OP_UNUSED, 8'hFF));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_idling(p % 4);
      set_count(phase_count[p]);
      run_traffic((ITEM_TARGET - sent) / (PHASES - p));
    end

    drain();
    if (errors == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
